@@ rtl/lru_key_value_cache_defines.svh @@
// Assertion macros for the files that check their own logic; the cache top includes them.
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked at every rising edge of clk, ignored while rst is high.
`define LKVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every rising edge of clk, reset included.
`define LKVC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LKVC_ASSERT(label, prop, msg)
`define LKVC_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ rtl/lkvc_pkg.sv @@
package lkvc_pkg;

  // Default number of entries and fixed field widths.
  localparam int unsigned MAX_ENTRIES_DEF = 16;
  localparam int unsigned KEY_BITS        = 16;
  localparam int unsigned VALUE_BITS      = 32;
  localparam int unsigned CFG_BITS        = 5;

  // Capacity after reset.
  localparam logic [CFG_BITS-1:0] CAP_RESET = 5'd16;

  // Request type codes.
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Controller states.
  typedef enum logic [0:0] {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic commit;
  } cmd_t;

endpackage

@@ rtl/lkvc_ctrl.sv @@
module lkvc_ctrl import lkvc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  output logic out_valid,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // The update waits until the output register is free.
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A committed request loads the output register; a taken beat empties it.
  always_comb begin
    if (cmd.commit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

@@ rtl/lkvc_datapath.sv @@
module lkvc_datapath import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic                   cfg_write_en,
  input  logic [CFG_BITS-1:0]    cfg_write_data,
  input  logic                   req_type,
  input  logic [KEY_BITS-1:0]    lookup_key,
  input  logic signed [VALUE_BITS-1:0] write_value,
  output logic                   hit,
  output logic signed [VALUE_BITS-1:0] read_value
);

  localparam int unsigned RANK_W = $clog2(MAX_ENTRIES);
  localparam int unsigned OCC_W  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W  = (OCC_W > CFG_BITS) ? OCC_W : CFG_BITS;

  // Entry storage.
  logic [MAX_ENTRIES-1:0] valid;
  logic [KEY_BITS-1:0]    keys   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0]  values [MAX_ENTRIES];
  logic [RANK_W-1:0]      ranks  [MAX_ENTRIES];
  logic [OCC_W-1:0]       occupancy;
  logic [CFG_BITS-1:0]    capacity;

  // Request captured in the lookup cycle.
  logic                   req_write;
  logic [KEY_BITS-1:0]    req_key;
  logic [VALUE_BITS-1:0]  req_value;
  logic [MAX_ENTRIES-1:0] match_vec;
  logic [VALUE_BITS-1:0]  hit_value;
  logic [RANK_W-1:0]      hit_rank;

  // Lookup logic.
  logic [MAX_ENTRIES-1:0] match_now;
  logic [VALUE_BITS-1:0]  hit_value_now;
  logic [RANK_W-1:0]      hit_rank_now;

  // Insert logic.
  logic                   req_hit;
  logic [CMP_W-1:0]       cap_ext;
  logic [CMP_W-1:0]       eff_cap;
  logic [CMP_W-1:0]       max_ext;
  logic                   full;
  logic [RANK_W-1:0]      oldest_rank;
  logic [MAX_ENTRIES-1:0] evict_vec;
  logic [MAX_ENTRIES-1:0] free_vec;
  logic [MAX_ENTRIES-1:0] sel_vec;

  // Compare the incoming key against every valid entry at once.
  // Keys of valid entries are unique, so at most one entry matches.
  always_comb begin
    hit_value_now = '0;
    hit_rank_now  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_now[i] = valid[i] && (keys[i] == lookup_key);
      if (match_now[i]) begin
        hit_value_now = hit_value_now | values[i];
        hit_rank_now  = hit_rank_now | ranks[i];
      end
    end
  end

  // Effective capacity: zero acts as one, and it saturates at the entry count.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    max_ext = CMP_W'(MAX_ENTRIES);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > max_ext) begin
      eff_cap = max_ext;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Ranks of valid entries form 0 .. occupancy-1, so the least recent entry
  // is the one whose rank equals occupancy-1.
  assign req_hit     = |match_vec;
  assign full        = CMP_W'(occupancy) >= eff_cap;
  assign oldest_rank = RANK_W'(occupancy - OCC_W'(1));

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      evict_vec[i] = full && valid[i] && (ranks[i] == oldest_rank);
    end
  end

  // The new key goes to the lowest free slot, counting the evicted one.
  assign free_vec = ~valid | evict_vec;
  assign sel_vec  = free_vec & (~free_vec + MAX_ENTRIES'(1));

  // Capacity register, valid bits, ranks and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      valid     <= '0;
      occupancy <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      if (cfg_write_en) begin
        capacity <= cfg_write_data;
      end
      if (cmd.commit) begin
        if (req_hit) begin
          // Touch the hit entry: entries more recent than it age by one.
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (match_vec[i]) begin
              ranks[i] <= '0;
            end else if (valid[i] && (ranks[i] < hit_rank)) begin
              ranks[i] <= ranks[i] + RANK_W'(1);
            end
          end
        end else if (req_write) begin
          // Insert: every remaining entry ages by one.
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (sel_vec[i]) begin
              valid[i] <= 1'b1;
              ranks[i] <= '0;
            end else if (evict_vec[i]) begin
              valid[i] <= 1'b0;
              ranks[i] <= '0;
            end else if (valid[i]) begin
              ranks[i] <= ranks[i] + RANK_W'(1);
            end
          end
          if (!full) begin
            occupancy <= occupancy + OCC_W'(1);
          end
        end
      end
    end
  end

  // Payload registers: request, keys, values and the result.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_write <= (req_type == REQ_WRITE);
      req_key   <= lookup_key;
      req_value <= write_value;
      match_vec <= match_now;
      hit_value <= hit_value_now;
      hit_rank  <= hit_rank_now;
    end
    if (cmd.commit) begin
      hit        <= req_hit;
      read_value <= (!req_write && req_hit) ? $signed(hit_value) : '0;
      if (req_write) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          if (req_hit ? match_vec[i] : sel_vec[i]) begin
            keys[i]   <= req_key;
            values[i] <= req_value;
          end
        end
      end
    end
  end

endmodule

@@ rtl/lru_key_value_cache.sv @@
// Fully associative key-value cache with least-recently-used replacement.
// Requests arrive on the in_ channel (req_type, lookup_key, write_value) and
// each one produces exactly one result beat on the out_ channel (hit,
// read_value). Both channels use valid/ready; a beat moves when both are high.
// One request is in flight at a time: it is accepted in one cycle, where all
// stored keys are compared against it in parallel, and committed once the
// output register is free, when recency ranks, keys and values are updated and
// the result is loaded into the output register. A new request is taken only
// after the last one has been committed; the parallel compare and the rank
// update are the two steps of each request.
// If the receiver stalls, the result waits in the output register; the next
// request may still be accepted, but its commit waits until the output
// register has been taken.
// The user writes capacity_in_use via cfg_write_en/cfg_write_data only while idle;
// the block does not enforce it. Synchronous reset empties the cache, clears
// all ranks and the occupancy count, sets the capacity to 16, drops any pending result.
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache import lkvc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write_en,
  input  logic [CFG_BITS-1:0]         cfg_write_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        req_type,
  input  logic [KEY_BITS-1:0]         lookup_key,
  input  logic signed [VALUE_BITS-1:0] write_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic signed [VALUE_BITS-1:0] read_value
);

  cmd_t cmd;

  // Sequencing of capture and commit.
  lkvc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Entry storage, compare and replacement.
  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .req_type       (req_type),
    .lookup_key     (lookup_key),
    .write_value    (write_value),
    .hit            (hit),
    .read_value     (read_value)
  );

  // A request is never captured and committed in the same cycle.
  `LKVC_ASSERT(a_no_overlap, !(cmd.capture && cmd.commit), "capture and commit overlap")
  // After a capture no second request is accepted until the commit.
  `LKVC_ASSERT(a_one_in_flight, cmd.capture |=> !in_ready, "second request accepted early")
  // A commit always presents a result in the next cycle.
  `LKVC_ASSERT(a_commit_result, cmd.commit |=> out_valid, "commit without result")
  // Reset drops any pending result.
  `LKVC_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid after reset")

endmodule

@@ bench/lru_key_value_cache_tb.sv @@
`timescale 1ns / 1ps

module lru_key_value_cache_tb;
  import lkvc_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 500_000;
  localparam int unsigned PHASES          = 10;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned POOL_MAX        = 20;
  localparam int unsigned DRAIN_CYCLES    = 8;
  localparam int unsigned DIRECTED_ROWS   = 23;

  // One result beat as the cache returns it.
  typedef struct packed {
    logic                         hit;
    logic signed [VALUE_BITS-1:0] value;
  } cache_result_t;

  typedef enum logic {
    ROW_ACCESS,
    ROW_CAPACITY
  } row_kind_t;

  // A directed row is either a request or a capacity change.
  typedef struct packed {
    row_kind_t                    kind;
    logic                         req;
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] data;
    logic [CFG_BITS-1:0]          cap;
    logic                         typed;
    cache_result_t                expected;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst;
  logic                         cfg_write_en;
  logic [CFG_BITS-1:0]          cfg_write_data;
  logic                         in_valid;
  logic                         in_ready;
  logic                         req_type;
  logic [KEY_BITS-1:0]          lookup_key;
  logic signed [VALUE_BITS-1:0] write_value;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic                         hit;
  logic signed [VALUE_BITS-1:0] read_value;

  // Shadow copy of the cache contents, ranks and capacity.
  bit                           shadow_valid [MAX_ENTRIES_DEF];
  logic [KEY_BITS-1:0]          shadow_key   [MAX_ENTRIES_DEF];
  logic signed [VALUE_BITS-1:0] shadow_value [MAX_ENTRIES_DEF];
  int unsigned                  shadow_rank  [MAX_ENTRIES_DEF];
  int unsigned                  shadow_count;
  logic [CFG_BITS-1:0]          shadow_capacity;

  cache_result_t expected_results [$];
  int unsigned   failures = 0;
  int unsigned   cycle_count = 0;
  int unsigned   hold_left = 0;
  bit            no_gaps = 1'b0;

  // Rank 0 is most recent; a typed row carries its expected beat directly.
  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ACCESS,   REQ_READ,  16'h0000, 32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'hFFFF, 32'h0000_0000, 5'd0,  1'b1, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h0000, 32'h8000_0000, 5'd0,  1'b1, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'hFFFF, 32'h7FFF_FFFF, 5'd0,  1'b1, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h0000, 32'hFFFF_FFFF, 5'd0,  1'b1, '{1'b1, 32'h8000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'hFFFF, 32'h0000_0000, 5'd0,  1'b1, '{1'b1, 32'h7FFF_FFFF}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h0000, 32'hFFFF_FFFF, 5'd0,  1'b1, '{1'b1, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h0000, 32'h5555_AAAA, 5'd0,  1'b1, '{1'b1, 32'hFFFF_FFFF}},
    '{ROW_CAPACITY, REQ_READ,  16'h0000, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h1234, 32'h0000_0001, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'hFFFF, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h0000, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h1234, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_CAPACITY, REQ_READ,  16'h0000, 32'h0000_0000, 5'd1,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h5678, 32'hAAAA_5555, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h0000, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_CAPACITY, REQ_READ,  16'h0000, 32'h0000_0000, 5'd31, 1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h0001, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h0002, 32'h5555_AAAA, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h5678, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_CAPACITY, REQ_READ,  16'h0000, 32'h0000_0000, 5'd16, 1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_WRITE, 16'h8000, 32'h1234_5678, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}},
    '{ROW_ACCESS,   REQ_READ,  16'h0001, 32'h0000_0000, 5'd0,  1'b0, '{1'b0, 32'h0000_0000}}
  };

  lru_key_value_cache dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .lookup_key     (lookup_key),
    .write_value    (write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .hit            (hit),
    .read_value     (read_value)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 55) begin
      return 0;
    end else if (pick < 90) begin
      return $urandom_range(1, 3);
    end else begin
      return $urandom_range(4, 24);
    end
  endfunction

  // Move one entry to the front; valid entries that were newer age by one.
  task automatic make_most_recent(input int slot);
    int unsigned old_rank;
    old_rank = shadow_rank[slot];
    for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
      if (shadow_valid[i] && i != slot && shadow_rank[i] < old_rank) begin
        shadow_rank[i]++;
      end
    end
    shadow_rank[slot] = 0;
  endtask

  // Look up one request in the shadow cache, update it and return the beat.
  task automatic lookup_and_update(input logic kind, input logic [KEY_BITS-1:0] key,
                                   input logic signed [VALUE_BITS-1:0] data,
                                   output cache_result_t res);
    int          slot;
    int          victim;
    int unsigned limit;
    slot = -1;
    victim = -1;
    for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) begin
        slot = i;
      end
    end
    res.hit = (slot >= 0);
    res.value = '0;
    if (slot >= 0) begin
      if (kind == REQ_READ) begin
        res.value = shadow_value[slot];
      end else begin
        shadow_value[slot] = data;
      end
      make_most_recent(slot);
    end else if (kind == REQ_WRITE) begin
      // A zero capacity behaves as one, anything past the array size saturates.
      limit = (shadow_capacity == 0) ? 1 : 32'(shadow_capacity);
      if (limit > MAX_ENTRIES_DEF) begin
        limit = MAX_ENTRIES_DEF;
      end
      // Full: drop only the single oldest entry, even if capacity shrank further.
      if (shadow_count >= limit) begin
        for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
          if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim])) begin
            victim = i;
          end
        end
        if (victim >= 0) begin
          shadow_valid[victim] = 1'b0;
          shadow_rank[victim] = 0;
          shadow_count--;
        end
      end
      // Insert into the lowest free slot as the newest entry.
      slot = -1;
      for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
        if (slot < 0 && !shadow_valid[i]) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
          if (shadow_valid[i]) begin
            shadow_rank[i]++;
          end
        end
        shadow_valid[slot] = 1'b1;
        shadow_key[slot] = key;
        shadow_value[slot] = data;
        shadow_rank[slot] = 0;
        shadow_count++;
      end
    end
  endtask

  // Present one request beat after a random gap and wait until it is taken.
  task automatic issue_request(input logic kind, input logic [KEY_BITS-1:0] key,
                               input logic signed [VALUE_BITS-1:0] data,
                               input logic typed, input cache_result_t typed_result);
    int unsigned   gap;
    cache_result_t predicted;
    gap = idle_length();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    lookup_key <= key;
    write_value <= data;
    do @(posedge clk); while (!in_ready);
    lookup_and_update(kind, key, data, predicted);
    expected_results.push_back(typed ? typed_result : predicted);
  endtask

  // Capacity changes only once every outstanding beat has come back.
  task automatic set_capacity(input logic [CFG_BITS-1:0] cap);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= cap;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    shadow_capacity = cap;
  endtask

  // Receiver: random stalls on out_ready.
  always @(posedge clk) begin
    int unsigned gap;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
    end else if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      gap = idle_length();
      out_ready <= (gap == 0);
      hold_left <= (gap == 0) ? 0 : gap - 1;
    end
  end

  // Compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    cache_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result beat: hit %0d read_value %0d", hit, read_value);
        failures++;
      end else begin
        want = expected_results.pop_front();
        if (hit !== want.hit) begin
          $error("hit: expected %0d, got %0d", want.hit, hit);
          failures++;
        end
        if (read_value !== want.value) begin
          $error("read_value: expected %0d, got %0d", want.value, read_value);
          failures++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [KEY_BITS-1:0]          key_pool [POOL_MAX];
    int unsigned                  pool_size;
    int unsigned                  usable;
    logic [CFG_BITS-1:0]          cap;
    logic                         kind;
    logic [KEY_BITS-1:0]          key;
    logic signed [VALUE_BITS-1:0] data;

    rst = 1'b1;
    cfg_write_en = 1'b0;
    cfg_write_data = '0;
    in_valid = 1'b0;
    req_type = REQ_READ;
    lookup_key = '0;
    write_value = '0;
    shadow_count = 0;
    shadow_capacity = CAP_RESET;
    for (int i = 0; i < MAX_ENTRIES_DEF; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = 0;
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: extremes of key and value, hits, misses, capacity corners.
    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      if (directed_rows[r].kind == ROW_CAPACITY) begin
        set_capacity(directed_rows[r].cap);
      end else begin
        issue_request(directed_rows[r].req, directed_rows[r].key, directed_rows[r].data,
                      directed_rows[r].typed, directed_rows[r].expected);
      end
    end

    // Random phases, each with its own capacity and a key pool sized near it
    // so that hits, updates and evictions all happen often.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: cap = 5'd16;
        1: cap = 5'd1;
        2: cap = 5'd0;
        3: cap = 5'd31;
        default: cap = CFG_BITS'($urandom_range(0, 31));
      endcase
      set_capacity(cap);
      no_gaps = (phase == 1) || ($urandom_range(0, 4) == 0);
      usable = (cap == 0) ? 1 : (cap > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : 32'(cap);
      pool_size = usable + $urandom_range(1, 4);
      for (int k = 0; k < pool_size; k++) begin
        key_pool[k] = KEY_BITS'($urandom_range(0, 65535));
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        kind = ($urandom_range(0, 1) != 0) ? REQ_WRITE : REQ_READ;
        if ($urandom_range(0, 99) < 85) begin
          key = key_pool[$urandom_range(0, pool_size - 1)];
        end else begin
          key = KEY_BITS'($urandom_range(0, 65535));
        end
        case ($urandom_range(0, 15))
          0: data = 32'h8000_0000;
          1: data = 32'h7FFF_FFFF;
          2: data = 32'hFFFF_FFFF;
          default: data = $urandom;
        endcase
        issue_request(kind, key, data, 1'b0, '0);
      end
    end

    // Drain, then keep watching for any stray beat to show up.
    in_valid <= 1'b0;
    no_gaps = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
